>>> hw/rtl/gdh_pkg.sv
// Shared types and constants of the density grid histogram.
// Used by gdh_div and gps_density_grid_histogram; depends on nothing.
`default_nettype none

package gdh_pkg;

  // Field widths.
  localparam int unsigned LAT_W      = 28;
  localparam int unsigned LON_W      = 29;
  localparam int unsigned CELL_W     = 20;
  localparam int unsigned SPEED_W    = 12;
  localparam int unsigned ROW_IN_W   = 9;
  localparam int unsigned COL_IN_W   = 10;
  localparam int unsigned COUNT_W    = 9;
  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 29;

  // Divider sizing: quotient bits for the largest grid edge of 4096 cells.
  localparam int unsigned QUOT_W     = 12;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned DIVIDEND_W = 29;
  localparam int unsigned DIVISOR_W  = CELL_W + QUOT_W;

  // Grid defaults.
  localparam int unsigned GRID_ROWS_DEF    = 512;
  localparam int unsigned GRID_COLUMNS_DEF = 1024;

  // Count saturation and pixel scale.
  localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(256);
  localparam logic [PIXEL_W-1:0] PIXEL_WHITE = PIXEL_W'(255);

  // Register reset values.
  localparam logic signed [LAT_W-1:0] ORIGIN_LAT_RST = LAT_W'(30380000);
  localparam logic signed [LON_W-1:0] ORIGIN_LON_RST = LON_W'(120010000);
  localparam logic [CELL_W-1:0]       CELL_SIZE_RST  = CELL_W'(230);
  localparam logic [SPEED_W-1:0]      MIN_SPEED_RST  = SPEED_W'(150);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_LAT = 2'd0,
    CFG_ORIGIN_LON = 2'd1,
    CFG_CELL_SIZE  = 2'd2,
    CFG_MIN_SPEED  = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [DIVISOR_W-1:0]  divisor_sh;  // cell size shifted up by the step count
    logic [STEP_W-1:0]     steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              ovf;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

>>> hw/rtl/gdh_div.sv
// Iterative restoring divider with an up-front range check, one quotient bit a cycle.
// Depends on gdh_pkg for widths and the request and response structs.
`default_nettype none

module gdh_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gdh_pkg::div_req_t req_i,
  output gdh_pkg::div_rsp_t      rsp_o
);

  logic                           busy_q, busy_d;
  logic                           chk_q, chk_d;
  logic                           done_q, done_d;
  logic                           ovf_q, ovf_d;
  logic [gdh_pkg::STEP_W-1:0]     cnt_q, cnt_d;
  logic [gdh_pkg::DIVIDEND_W-1:0] rem_q, rem_d;
  logic [gdh_pkg::DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [gdh_pkg::QUOT_W-1:0]     quot_q, quot_d;
  logic [gdh_pkg::DIVISOR_W-1:0]  rem_ext;
  logic [gdh_pkg::DIVISOR_W-1:0]  diff;
  logic                           ge;

  assign rem_ext = gdh_pkg::DIVISOR_W'(rem_q);
  assign ge      = (rem_ext >= dvs_q);
  assign diff    = rem_ext - dvs_q;

  always_comb begin
    busy_d = busy_q;
    chk_d  = chk_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quot_d = quot_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      chk_d  = 1'b1;
      ovf_d  = 1'b0;
      cnt_d  = req_i.steps;
      rem_d  = req_i.dividend;
      dvs_d  = req_i.divisor_sh;
      quot_d = '0;
    end else if (busy_q) begin
      if (chk_q) begin
        // A dividend at or above divisor << steps has a quotient too wide for the grid.
        // A zero divisor lands here as well.
        if (ge) begin
          ovf_d  = 1'b1;
          done_d = 1'b1;
          busy_d = 1'b0;
        end else begin
          chk_d = 1'b0;
          dvs_d = dvs_q >> 1;
        end
      end else begin
        quot_d = {quot_q[gdh_pkg::QUOT_W-2:0], ge};
        if (ge) begin
          rem_d = diff[gdh_pkg::DIVIDEND_W-1:0];
        end
        dvs_d = dvs_q >> 1;
        cnt_d = cnt_q - gdh_pkg::STEP_W'(1);
        if (cnt_q == gdh_pkg::STEP_W'(1)) begin
          done_d = 1'b1;
          busy_d = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      chk_q  <= 1'b0;
      done_q <= 1'b0;
      ovf_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      chk_q  <= chk_d;
      done_q <= done_d;
      ovf_q  <= ovf_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    quot_q <= quot_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.ovf  = ovf_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

>>> hw/rtl/gps_density_grid_histogram.sv
// Density grid histogram: top level with sequencer, cell count memory and registers.
// Depends on gdh_pkg and instantiates gdh_div.
//
// Usage: a request is taken at a rising edge with start_i high and busy_o low.
// operation_i selects an add (position point) or a read of one cell. Every request
// gives exactly one result, shown for a single cycle with done_o high together
// with accepted_o and pixel_o; the receiver cannot stall it and must take it then.
// An add maps the point to a cell with two divisions by the cell size, run on one
// shared restoring divider: a range check and then one quotient bit per row index
// bit, then the same for the column, then a read and a write of the cell memory.
// A point rejected on speed or a negative offset, or a read outside the grid, is
// answered from the idle state without the divider or the memory; a read inside
// the grid goes through the lookup and update states.
// busy_o stays high until the result is issued; a new request may be given in the
// cycle in which done_o is high.
// After reset the block sweeps the cell memory to zero, one entry a cycle, over all
// GRID_ROWS * 2**clog2(GRID_COLUMNS) entries (524288 by default) with busy_o high.
// Configuration writes on cfg_we_i are taken at any time, but are only meant
// to be given while no request is in flight.
`default_nettype none

module gps_density_grid_histogram #(
  parameter int unsigned GRID_ROWS    = gdh_pkg::GRID_ROWS_DEF,
  parameter int unsigned GRID_COLUMNS = gdh_pkg::GRID_COLUMNS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [gdh_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [gdh_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic                                operation_i,
  input  wire logic signed [gdh_pkg::LAT_W-1:0]    latitude_i,
  input  wire logic signed [gdh_pkg::LON_W-1:0]    longitude_i,
  input  wire logic [gdh_pkg::SPEED_W-1:0]         speed_i,
  input  wire logic [gdh_pkg::ROW_IN_W-1:0]        read_row_i,
  input  wire logic [gdh_pkg::COL_IN_W-1:0]        read_column_i,
  output logic                                     done_o,
  output logic                                     accepted_o,
  output logic [gdh_pkg::PIXEL_W-1:0]              pixel_o
);

  localparam int unsigned RB    = $clog2(GRID_ROWS);
  localparam int unsigned CB    = $clog2(GRID_COLUMNS);
  localparam int unsigned AW    = RB + CB;
  localparam int unsigned DEPTH = GRID_ROWS * (2 ** CB);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_ROW    = 6'b000100,
    ST_COL    = 6'b001000,
    ST_LOOKUP = 6'b010000,
    ST_UPDATE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic signed [gdh_pkg::LAT_W-1:0] origin_lat_q;
  logic signed [gdh_pkg::LON_W-1:0] origin_lon_q;
  logic [gdh_pkg::CELL_W-1:0]       cell_size_q;
  logic [gdh_pkg::SPEED_W-1:0]      min_speed_q;

  // Request context.
  logic                             op_q, op_d;
  logic [gdh_pkg::DIVIDEND_W-1:0]   dlon_q, dlon_d;
  logic [RB-1:0]                    row_q, row_d;
  logic [CB-1:0]                    col_q, col_d;
  logic [AW-1:0]                    clr_q, clr_d;

  // Result registers.
  logic                             done_q, done_d;
  logic                             acc_q, acc_d;
  logic [gdh_pkg::PIXEL_W-1:0]      pixel_q, pixel_d;

  // Cell count memory.
  logic [gdh_pkg::COUNT_W-1:0]      mem [DEPTH];
  logic [gdh_pkg::COUNT_W-1:0]      rd_q;
  logic [gdh_pkg::COUNT_W-1:0]      mem_wdata;
  logic [AW-1:0]                    mem_addr;
  logic                             mem_we;
  logic                             mem_re;

  gdh_pkg::div_req_t                div_req;
  gdh_pkg::div_rsp_t                div_rsp;

  logic signed [gdh_pkg::LAT_W:0]   dlat;
  logic signed [gdh_pkg::LON_W:0]   dlon;
  logic                             add_reject;
  logic                             read_in_grid;

  assign dlat = {origin_lat_q[gdh_pkg::LAT_W-1], origin_lat_q}
              - {latitude_i[gdh_pkg::LAT_W-1], latitude_i};
  assign dlon = {longitude_i[gdh_pkg::LON_W-1], longitude_i}
              - {origin_lon_q[gdh_pkg::LON_W-1], origin_lon_q};

  assign add_reject = (speed_i < min_speed_q) || dlat[gdh_pkg::LAT_W] || dlon[gdh_pkg::LON_W];
  assign read_in_grid = (32'(read_row_i) < 32'(GRID_ROWS))
                     && (32'(read_column_i) < 32'(GRID_COLUMNS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_lat_q <= gdh_pkg::ORIGIN_LAT_RST;
      origin_lon_q <= gdh_pkg::ORIGIN_LON_RST;
      cell_size_q  <= gdh_pkg::CELL_SIZE_RST;
      min_speed_q  <= gdh_pkg::MIN_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (gdh_pkg::cfg_idx_e'(cfg_idx_i))
        gdh_pkg::CFG_ORIGIN_LAT: origin_lat_q <= signed'(cfg_data_i[gdh_pkg::LAT_W-1:0]);
        gdh_pkg::CFG_ORIGIN_LON: origin_lon_q <= signed'(cfg_data_i[gdh_pkg::LON_W-1:0]);
        gdh_pkg::CFG_CELL_SIZE:  cell_size_q  <= cfg_data_i[gdh_pkg::CELL_W-1:0];
        gdh_pkg::CFG_MIN_SPEED:  min_speed_q  <= cfg_data_i[gdh_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    dlon_d    = dlon_q;
    row_d     = row_q;
    col_d     = col_q;
    clr_d     = clr_q;
    done_d    = 1'b0;
    acc_d     = 1'b0;
    pixel_d   = '0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_addr  = {row_q, col_q};
    mem_wdata = '0;
    div_req.start      = 1'b0;
    div_req.dividend   = {1'b0, dlat[gdh_pkg::LAT_W-1:0]};
    div_req.divisor_sh = gdh_pkg::DIVISOR_W'(cell_size_q) << RB;
    div_req.steps      = gdh_pkg::STEP_W'(RB);

    unique case (state_q)
      ST_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_q;
        clr_d    = clr_q + AW'(1);
        if (clr_q == AW'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d   = operation_i;
          dlon_d = dlon[gdh_pkg::LON_W-1:0];
          row_d  = RB'(read_row_i);
          col_d  = CB'(read_column_i);
          if (gdh_pkg::op_e'(operation_i) == gdh_pkg::OP_READ) begin
            if (read_in_grid) begin
              state_d = ST_LOOKUP;
            end else begin
              done_d  = 1'b1;
              pixel_d = gdh_pkg::PIXEL_WHITE;
            end
          end else if (add_reject) begin
            done_d = 1'b1;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_ROW;
          end
        end
      end
      ST_ROW: begin
        div_req.dividend   = dlon_q;
        div_req.divisor_sh = gdh_pkg::DIVISOR_W'(cell_size_q) << CB;
        div_req.steps      = gdh_pkg::STEP_W'(CB);
        if (div_rsp.done) begin
          row_d = div_rsp.quot[RB-1:0];
          if (div_rsp.ovf || (32'(div_rsp.quot) >= 32'(GRID_ROWS))) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            div_req.start = 1'b1;
            state_d       = ST_COL;
          end
        end
      end
      ST_COL: begin
        if (div_rsp.done) begin
          col_d = div_rsp.quot[CB-1:0];
          if (div_rsp.ovf || (32'(div_rsp.quot) >= 32'(GRID_COLUMNS))) begin
            done_d  = 1'b1;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        mem_re  = 1'b1;
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (gdh_pkg::op_e'(op_q) == gdh_pkg::OP_ADD) begin
          // The count saturates one above the pixel scale.
          mem_we    = 1'b1;
          mem_wdata = (rd_q == gdh_pkg::COUNT_LIMIT) ? rd_q : rd_q + gdh_pkg::COUNT_W'(1);
          acc_d     = 1'b1;
        end else if (rd_q[gdh_pkg::COUNT_W-1]) begin
          pixel_d = '0;
        end else begin
          pixel_d = gdh_pkg::PIXEL_WHITE - rd_q[gdh_pkg::PIXEL_W-1:0];
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    dlon_q  <= dlon_d;
    row_q   <= row_d;
    col_q   <= col_d;
    acc_q   <= acc_d;
    pixel_q <= pixel_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_addr];
    end
  end

  gdh_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign busy_o     = (state_q != ST_IDLE);
  assign done_o     = done_q;
  assign accepted_o = acc_q;
  assign pixel_o    = pixel_q;

endmodule

`default_nettype wire

>>> tb/gps_density_grid_histogram_tb.sv
// Self-checking testbench for the density grid histogram: directed table, then random requests.
// A behavioural model of the grid predicts every result the table does not fix; depends on gdh_pkg and the top level.
module gps_density_grid_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gdh_pkg::*;

  localparam int unsigned ROWS        = GRID_ROWS_DEF;
  localparam int unsigned COLS        = GRID_COLUMNS_DEF;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned SETTLE      = 40;

  typedef struct {
    op_e                      op;
    logic signed [LAT_W-1:0]  lat;
    logic signed [LON_W-1:0]  lon;
    logic [SPEED_W-1:0]       speed;
    logic [ROW_IN_W-1:0]      rrow;
    logic [COL_IN_W-1:0]      rcol;
  } point_req_t;

  typedef struct {
    logic               acc;
    logic [PIXEL_W-1:0] pix;
  } outcome_t;

  typedef enum {STEP_REQ, STEP_CFG} step_kind_e;

  typedef struct {
    step_kind_e kind;
    point_req_t req;
    bit         fixed;
    outcome_t   want;
    cfg_idx_e   idx;
    longint     value;
  } tbl_step_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_IDX_W-1:0]    cfg_idx_i;
  logic [CFG_DATA_W-1:0]   cfg_data_i;
  logic                    start_i;
  logic                    busy_o;
  logic                    operation_i;
  logic signed [LAT_W-1:0] latitude_i;
  logic signed [LON_W-1:0] longitude_i;
  logic [SPEED_W-1:0]      speed_i;
  logic [ROW_IN_W-1:0]     read_row_i;
  logic [COL_IN_W-1:0]     read_column_i;
  logic                    done_o;
  logic                    accepted_o;
  logic [PIXEL_W-1:0]      pixel_o;

  // Model state of the grid and its registers.
  logic signed [LAT_W-1:0] org_lat_q   = ORIGIN_LAT_RST;
  logic signed [LON_W-1:0] org_lon_q   = ORIGIN_LON_RST;
  logic [CELL_W-1:0]       cell_size_q = CELL_SIZE_RST;
  logic [SPEED_W-1:0]      min_speed_q = MIN_SPEED_RST;
  bit [COUNT_W-1:0]        cell_count_q [ROWS*COLS];

  outcome_t    outcome_q [$];
  outcome_t    no_outcome = '{acc: 1'b0, pix: '0};
  tbl_step_t   directed_q [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned hot_row, hot_col, last_row, last_col;

  gps_density_grid_histogram #(
    .GRID_ROWS    (ROWS),
    .GRID_COLUMNS (COLS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .operation_i   (operation_i),
    .latitude_i    (latitude_i),
    .longitude_i   (longitude_i),
    .speed_i       (speed_i),
    .read_row_i    (read_row_i),
    .read_column_i (read_column_i),
    .done_o        (done_o),
    .accepted_o    (accepted_o),
    .pixel_o       (pixel_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Bins a point or reads a cell, updating the model counts on an add.
  function automatic outcome_t grid_outcome(input point_req_t r);
    outcome_t    o;
    longint      dlat, dlon, row, col;
    int unsigned idx;
    o = no_outcome;
    if (r.op == OP_READ) begin
      if (r.rrow >= ROWS || r.rcol >= COLS) begin
        o.pix = PIXEL_WHITE;
      end else begin
        idx = r.rrow * COLS + r.rcol;
        o.pix = (cell_count_q[idx] > PIXEL_WHITE) ? '0 : PIXEL_W'(PIXEL_WHITE - cell_count_q[idx]);
      end
    end else if (r.speed >= min_speed_q && cell_size_q != 0) begin
      dlat = longint'(org_lat_q) - longint'(r.lat);
      dlon = longint'(r.lon) - longint'(org_lon_q);
      if (dlat >= 0 && dlon >= 0) begin
        row = dlat / longint'(cell_size_q);
        col = dlon / longint'(cell_size_q);
        if (row < ROWS && col < COLS) begin
          idx = int'(row) * COLS + int'(col);
          if (cell_count_q[idx] < COUNT_LIMIT) cell_count_q[idx]++;
          o.acc = 1'b1;
        end
      end
    end
    return o;
  endfunction

  function automatic point_req_t add_pt(input longint lat, input longint lon, input int spd);
    point_req_t r;
    r.op    = OP_ADD;
    r.lat   = lat[LAT_W-1:0];
    r.lon   = lon[LON_W-1:0];
    r.speed = SPEED_W'(spd);
    r.rrow  = '0;
    r.rcol  = '0;
    return r;
  endfunction

  function automatic point_req_t read_pt(input int row, input int col);
    point_req_t r;
    r       = add_pt(0, 0, 0);
    r.op    = OP_READ;
    r.rrow  = ROW_IN_W'(row);
    r.rcol  = COL_IN_W'(col);
    return r;
  endfunction

  function automatic tbl_step_t req_step(input point_req_t r, input bit fixed,
                                         input bit acc, input int pix);
    tbl_step_t s;
    s.kind     = STEP_REQ;
    s.req      = r;
    s.fixed    = fixed;
    s.want.acc = acc;
    s.want.pix = PIXEL_W'(pix);
    s.idx      = CFG_ORIGIN_LAT;
    s.value    = 0;
    return s;
  endfunction

  function automatic tbl_step_t cfg_step(input cfg_idx_e idx, input longint value);
    tbl_step_t s;
    s       = req_step(read_pt(0, 0), 1'b0, 1'b0, 0);
    s.kind  = STEP_CFG;
    s.idx   = idx;
    s.value = value;
    return s;
  endfunction

  function automatic void append_step(input tbl_step_t s);
    directed_q = {directed_q, s};
  endfunction

  // Mostly well-formed adds aimed at the grid, some reads, some raw noise.
  function automatic point_req_t random_point(input int unsigned hot_pct);
    point_req_t  r;
    int unsigned pick, row, col;
    longint      cs, dlat, dlon;
    cs      = longint'(cell_size_q);
    r.op    = OP_ADD;
    r.lat   = LAT_W'($urandom);
    r.lon   = LON_W'($urandom);
    r.speed = SPEED_W'($urandom);
    r.rrow  = ROW_IN_W'($urandom);
    r.rcol  = COL_IN_W'($urandom);
    pick    = $urandom_range(99);
    if (pick < 20) begin
      r.op = op_e'($urandom_range(1));
    end else if (pick < 45) begin
      r.op = OP_READ;
      case ($urandom_range(3))
        0, 1: begin
          r.rrow = ROW_IN_W'(last_row);
          r.rcol = COL_IN_W'(last_col);
        end
        2: begin
          r.rrow = ROW_IN_W'(hot_row);
          r.rcol = COL_IN_W'(hot_col);
        end
        default: ;
      endcase
    end else begin
      if ($urandom_range(99) < hot_pct) begin
        row = hot_row;
        col = hot_col;
      end else begin
        row = $urandom_range(ROWS - 1);
        col = $urandom_range(COLS - 1);
      end
      case ($urandom_range(19))
        0: row = $urandom_range(ROWS + 80, ROWS);
        1: col = $urandom_range(COLS + 80, COLS);
        default: ;
      endcase
      dlat = longint'(row) * cs;
      dlon = longint'(col) * cs;
      if (cs > 0) begin
        dlat += longint'($urandom_range(int'(cs) - 1));
        dlon += longint'($urandom_range(int'(cs) - 1));
      end
      case ($urandom_range(19))
        0: dlat = -longint'($urandom_range(1000, 1));
        1: dlon = -longint'($urandom_range(1000, 1));
        default: ;
      endcase
      r.lat = LAT_W'(longint'(org_lat_q) - dlat);
      r.lon = LON_W'(longint'(org_lon_q) + dlon);
      if (min_speed_q != 0 && $urandom_range(9) == 0) begin
        r.speed = SPEED_W'($urandom_range(min_speed_q - 1));
      end else begin
        r.speed = SPEED_W'($urandom_range(4095, min_speed_q));
      end
      last_row = row;
      last_col = col;
    end
    return r;
  endfunction

  task automatic issue_request(input point_req_t r, input bit fixed, input outcome_t want);
    outcome_t predicted;
    start_i       <= 1'b1;
    cfg_we_i      <= 1'b0;
    operation_i   <= r.op;
    latitude_i    <= r.lat;
    longitude_i   <= r.lon;
    speed_i       <= r.speed;
    read_row_i    <= r.rrow;
    read_column_i <= r.rcol;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    predicted = grid_outcome(r);
    if (fixed) predicted = want;
    outcome_q = {outcome_q, predicted};
  endtask

  task automatic hold_off(input int unsigned cycles);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  task automatic wait_grid_idle();
    start_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // Leaves the write enable high; the next request lowers it.
  task automatic write_reg(input cfg_idx_e idx, input longint value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(posedge clk_i);
    case (idx)
      CFG_ORIGIN_LAT: org_lat_q   = value[LAT_W-1:0];
      CFG_ORIGIN_LON: org_lon_q   = value[LON_W-1:0];
      CFG_CELL_SIZE:  cell_size_q = value[CELL_W-1:0];
      CFG_MIN_SPEED:  min_speed_q = value[SPEED_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input longint lat, input longint lon,
                           input longint cell_edge, input longint spd);
    wait_grid_idle();
    write_reg(CFG_ORIGIN_LAT, lat);
    write_reg(CFG_ORIGIN_LON, lon);
    write_reg(CFG_CELL_SIZE, cell_edge);
    write_reg(CFG_MIN_SPEED, spd);
  endtask

  task automatic run_phase(input int unsigned n_items, input int unsigned idle_pct,
                           input int unsigned hot_pct);
    int unsigned gap;
    int unsigned calm;
    calm    = 0;
    hot_row = $urandom_range(3);
    hot_col = $urandom_range(3);
    for (int unsigned i = 0; i < n_items; i++) begin
      issue_request(random_point(hot_pct), 1'b0, no_outcome);
      gap = 0;
      if (calm > 0) begin
        calm--;
      end else if ($urandom_range(99) < 4) begin
        calm = $urandom_range(30, 10);
      end else begin
        while (gap < 64 && $urandom_range(99) < idle_pct) gap++;
      end
      hold_off(gap);
      if ($urandom_range(199) == 0) wait_grid_idle();
    end
  endtask

  always @(posedge clk_i) begin : result_check
    outcome_t want;
    if (rst_ni === 1'b1 && done_o === 1'b1) begin
      if (outcome_q.size() == 0) begin
        error_count++;
        $display("%0t: result with no request pending, accepted %0b pixel %0d",
                 $time, accepted_o, pixel_o);
      end else begin
        want = outcome_q.pop_front();
        if (accepted_o !== want.acc) begin
          error_count++;
          $display("%0t: accepted expected %0b got %0b", $time, want.acc, accepted_o);
        end
        if (pixel_o !== want.pix) begin
          error_count++;
          $display("%0t: pixel expected %0d got %0d", $time, want.pix, pixel_o);
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_idx_i     <= '0;
    cfg_data_i    <= '0;
    start_i       <= 1'b0;
    operation_i   <= 1'b0;
    latitude_i    <= '0;
    longitude_i   <= '0;
    speed_i       <= '0;
    read_row_i    <= '0;
    read_column_i <= '0;
    last_row      = 0;
    last_col      = 0;
    hot_row       = 0;
    hot_col       = 0;

    // Reset registers: the corner cells sit 511*230+229 and 1023*230+229 from the origin.
    append_step(req_step(read_pt(0, 0), 1, 0, 255));
    append_step(req_step(read_pt(511, 1023), 1, 0, 255));
    append_step(req_step(add_pt(30380000, 120010000, 150), 1, 1, 0));
    append_step(req_step(read_pt(0, 0), 1, 0, 254));
    append_step(req_step(add_pt(30380000, 120010000, 149), 1, 0, 0));
    append_step(req_step(add_pt(30380001, 120010000, 4095), 1, 0, 0));
    append_step(req_step(add_pt(30380000, 120009999, 4095), 1, 0, 0));
    append_step(req_step(add_pt(30262241, 120245519, 300), 1, 1, 0));
    append_step(req_step(read_pt(511, 1023), 1, 0, 254));
    append_step(req_step(add_pt(30262240, 120010000, 300), 1, 0, 0));
    append_step(req_step(add_pt(30380000, 120245520, 300), 1, 0, 0));
    append_step(req_step(add_pt(-134217728, 268435455, 4095), 1, 0, 0));
    append_step(req_step(add_pt(134217727, -268435456, 0), 1, 0, 0));
    append_step(req_step(add_pt(30379771, 120010229, 150), 0, 0, 0));
    append_step(req_step(read_pt(0, 0), 0, 0, 0));
    append_step(req_step(read_pt(511, 0), 0, 0, 0));
    append_step(req_step(read_pt(0, 1023), 0, 0, 0));
    // With a zero cell size nothing can be binned.
    append_step(cfg_step(CFG_CELL_SIZE, 0));
    append_step(req_step(add_pt(30380000, 120010000, 4095), 1, 0, 0));
    append_step(req_step(add_pt(30262241, 120245519, 4095), 1, 0, 0));
    append_step(cfg_step(CFG_CELL_SIZE, 230));
    append_step(cfg_step(CFG_MIN_SPEED, 0));
    append_step(req_step(add_pt(30378850, 120011610, 0), 0, 0, 0));
    append_step(req_step(read_pt(5, 7), 0, 0, 0));
    append_step(req_step(read_pt(0, 0), 0, 0, 0));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The first request waits out the clearing sweep that follows reset.
    foreach (directed_q[i]) begin
      if (directed_q[i].kind == STEP_CFG) begin
        wait_grid_idle();
        write_reg(directed_q[i].idx, directed_q[i].value);
      end else begin
        issue_request(directed_q[i].req, directed_q[i].fixed, directed_q[i].want);
      end
    end

    configure(ORIGIN_LAT_RST, ORIGIN_LON_RST, CELL_SIZE_RST, MIN_SPEED_RST);
    run_phase(250, 0, 20);
    configure(90000000, -180000000, 1, 0);
    run_phase(250, 74, 30);
    // A large cell and a narrow hot spot pile many points onto one cell.
    configure(-90000000, 180000000, 1000000, 4095);
    run_phase(350, 29, 90);
    configure(longint'($urandom_range(180000000)) - 90000000,
              longint'($urandom_range(360000000)) - 180000000,
              $urandom_range(5000, 1), $urandom_range(4095));
    run_phase(150, 0, 40);

    wait_grid_idle();
    repeat (SETTLE) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
